FILE: rtl/pressure_temp_compensation_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pressure and temperature compensation block.
// They expect signals named clk and rst in the scope of use.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptc assertion failed");

// Delayed implication, the delay given by n, checked outside reset.
`define PTC_ASSERT_DLY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("ptc delayed assertion failed");

`endif

FILE: rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// Types, constants and helpers shared by the compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

  // One raw reading pair.
  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
  } ptc_in_t;

  // One compensated result.
  typedef struct packed {
    logic signed [31:0] fine_temp;
    logic signed [15:0] temp_centi;
    logic [31:0]        pressure_q24_8;
    logic               press_valid;
  } ptc_out_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_TEMP_CALIB    = 2'd0;
  localparam logic [1:0] REG_PRESS_CALIB_A = 2'd1;
  localparam logic [1:0] REG_PRESS_CALIB_B = 2'd2;
  localparam logic [1:0] REG_PRESS_CALIB_C = 2'd3;

  // Formula constants.
  localparam logic [63:0] T_OFFSET   = 64'd128000;
  localparam logic [63:0] P_SCALE    = 64'd3125;
  localparam logic [63:0] P_BASE     = 64'd1048576;
  localparam logic [63:0] V1_BIAS    = 64'd1 << 47;

  // Pipeline depths.
  localparam int TEMP_LAT = 5;
  localparam int MUL_LAT  = 2;
  localparam int DIV_LAT  = 66;
  localparam int PTC_LAT  = 88;

  // Sign-extend a 16-bit calibration word to 64 bits.
  function automatic logic [63:0] sx16(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

FILE: rtl/ptc_delay.sv
// ----------------------------------------------------------------------------
// ptc_delay
// Fixed-depth shift line that carries side data alongside the pipeline.
// ----------------------------------------------------------------------------
module ptc_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  // Shift one place per cycle.
  always_ff @(posedge clk) begin
    line[0] <= din;
    for (int k = 1; k < DEPTH; k++) begin
      line[k] <= line[k-1];
    end
  end

  assign dout = line[DEPTH-1];

endmodule

FILE: rtl/ptc_mul64.sv
// ----------------------------------------------------------------------------
// ptc_mul64
// Two-stage 64x64 multiplier that keeps the low 64 bits of the product.
// ----------------------------------------------------------------------------
module ptc_mul64 (
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  // First stage: three 32x32 partial products; the high-high term drops out.
  always_ff @(posedge clk) begin
    ll <= a[31:0] * b[31:0];
    lh <= 32'(a[31:0] * b[63:32]);
    hl <= 32'(a[63:32] * b[31:0]);
  end

  // Second stage: fold the cross terms into the upper word.
  always_ff @(posedge clk) begin
    p <= ll + {lh + hl, 32'd0};
  end

endmodule

FILE: rtl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined signed 64-bit divider, truncating toward zero, one quotient bit
// per stage. A zero divisor gives a meaningless quotient.
// ----------------------------------------------------------------------------
module ptc_div (
  input  logic        clk,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic [63:0] quotient
);

  logic [63:0] rem  [65];
  logic [63:0] nq   [65];
  logic [63:0] md   [65];
  logic        neg  [65];
  logic [63:0] mag_n;
  logic [63:0] mag_d;

  // Magnitudes of the operands.
  assign mag_n = dividend[63] ? (64'd0 - dividend) : dividend;
  assign mag_d = divisor[63]  ? (64'd0 - divisor)  : divisor;

  // Entry stage.
  always_ff @(posedge clk) begin
    rem[0] <= 64'd0;
    nq[0]  <= mag_n;
    md[0]  <= mag_d;
    neg[0] <= dividend[63] ^ divisor[63];
  end

  // Restoring steps, most significant quotient bit first.
  for (genvar i = 0; i < 64; i++) begin : g_step
    logic [64:0] trial;
    logic        fits;

    assign trial = {rem[i], nq[i][63]};
    assign fits  = (trial >= {1'b0, md[i]});

    always_ff @(posedge clk) begin
      rem[i+1] <= fits ? 64'(trial - {1'b0, md[i]}) : trial[63:0];
      nq[i+1]  <= {nq[i][62:0], fits};
      md[i+1]  <= md[i];
      neg[i+1] <= neg[i];
    end
  end

  // Apply the sign of the result.
  always_ff @(posedge clk) begin
    quotient <= neg[64] ? (64'd0 - nq[64]) : nq[64];
  end

endmodule

FILE: rtl/ptc_temp.sv
// ----------------------------------------------------------------------------
// ptc_temp
// Five-stage temperature compensation in 32-bit wrapping arithmetic. Gives
// the fine temperature and the saturated temperature in hundredths.
// ----------------------------------------------------------------------------
module ptc_temp
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic [47:0] calib,
  input  logic [19:0] raw_temp,
  output logic [31:0] tf,
  output logic [15:0] tcs
);

  logic [15:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;
  logic [31:0] a;
  logic [31:0] d;
  logic [31:0] pa;
  logic [31:0] dd;
  logic [31:0] dd_sh;
  logic [31:0] tv1;
  logic [31:0] m;
  logic [31:0] m_sh;
  logic [31:0] tf4;
  logic [31:0] tc;

  // Calibration words.
  assign t1 = calib[15:0];
  assign t2 = {{16{calib[31]}}, calib[31:16]};
  assign t3 = {{16{calib[47]}}, calib[47:32]};

  // Stage 1: offsets of the reading against T1.
  always_ff @(posedge clk) begin
    a <= {15'd0, raw_temp[19:3]} - {15'd0, t1, 1'b0};
    d <= {16'd0, raw_temp[19:4]} - {16'd0, t1};
  end

  // Stage 2: linear term and square.
  always_ff @(posedge clk) begin
    pa <= a * t2;
    dd <= d * d;
  end

  // Stage 3: scale the linear term and weight the square.
  assign dd_sh = $signed(dd) >>> 12;
  always_ff @(posedge clk) begin
    tv1 <= $signed(pa) >>> 11;
    m   <= dd_sh * t3;
  end

  // Stage 4: fine temperature.
  assign m_sh = $signed(m) >>> 14;
  always_ff @(posedge clk) begin
    tf4 <= tv1 + m_sh;
  end

  // Stage 5: hundredths of a degree, saturated to 16 bits signed.
  assign tc = $signed((tf4 << 2) + tf4 + 32'd128) >>> 8;
  always_ff @(posedge clk) begin
    tf <= tf4;
    if ($signed(tc) < -32'sd32768) begin
      tcs <= 16'h8000;
    end else if ($signed(tc) > 32'sd32767) begin
      tcs <= 16'h7fff;
    end else begin
      tcs <= tc[15:0];
    end
  end

endmodule

FILE: rtl/pressure_temp_compensation.sv
// Done is the end of a valid chain that carries each accepted start.
// Throughput: one reading pair per cycle; busy is never raised.
// The depth is set by the 64-step pipelined divider and the 64-bit multipliers.
// Reset clears the calibration registers and the valid chain.
// Results cannot be held off: each shows for one cycle with done.
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Integer temperature and pressure compensation of a barometric sensor,
// fully pipelined, with four calibration registers on a write port.
// ----------------------------------------------------------------------------
module pressure_temp_compensation
  import ptc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  ptc_in_t     sample,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        done,
  output ptc_out_t    result
);

  logic [47:0] temp_calib;
  logic [47:0] press_calib_a;
  logic [47:0] press_calib_b;
  logic [47:0] press_calib_c;
  logic [PTC_LAT-1:0] vld;

  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;

  logic [31:0] tf5;
  logic [15:0] tcs5;
  logic [47:0] side87;
  logic [19:0] adc13;
  logic [63:0] x;
  logic [63:0] sq8, c8, e8, c10, e10, b10, d10;
  logic [63:0] d10_sh;
  logic [63:0] v2, v1b, v2_13, f13, f13_sh;
  logic [63:0] v1c, num, g16, v1c16;
  logic        zero87;
  logic [63:0] q82, ph82, ph84, q84, q86, h84, j84, j86, i86;
  logic [63:0] i86_sh, j86_sh, s, s_sh, pfin;
  logic [31:0] press_sat;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib    <= '0;
      press_calib_a <= '0;
      press_calib_b <= '0;
      press_calib_c <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TEMP_CALIB:    temp_calib    <= cfg_data;
        REG_PRESS_CALIB_A: press_calib_a <= cfg_data;
        REG_PRESS_CALIB_B: press_calib_b <= cfg_data;
        REG_PRESS_CALIB_C: press_calib_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid chain travelling with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[PTC_LAT-2:0], start && !busy};
    end
  end

  // Pressure calibration words.
  assign p1 = {48'd0, press_calib_a[15:0]};
  assign p2 = sx16(press_calib_a[31:16]);
  assign p3 = sx16(press_calib_a[47:32]);
  assign p4 = sx16(press_calib_b[15:0]);
  assign p5 = sx16(press_calib_b[31:16]);
  assign p6 = sx16(press_calib_b[47:32]);
  assign p7 = sx16(press_calib_c[15:0]);
  assign p8 = sx16(press_calib_c[31:16]);
  assign p9 = sx16(press_calib_c[47:32]);

  // Temperature stages.
  ptc_temp u_temp (
    .clk      (clk),
    .calib    (temp_calib),
    .raw_temp (sample.raw_temp),
    .tf       (tf5),
    .tcs      (tcs5)
  );

  ptc_delay #(.WIDTH(48), .DEPTH(PTC_LAT - 1 - TEMP_LAT)) u_side_dly (
    .clk (clk), .din ({tf5, tcs5}), .dout (side87)
  );

  ptc_delay #(.WIDTH(20), .DEPTH(13)) u_adc_dly (
    .clk (clk), .din (sample.raw_press), .dout (adc13)
  );

  // Offset fine temperature.
  always_ff @(posedge clk) begin
    x <= {{32{tf5[31]}}, tf5} - T_OFFSET;
  end

  // Square and linear terms.
  ptc_mul64 u_mul_sq (.clk(clk), .a(x), .b(x),  .p(sq8));
  ptc_mul64 u_mul_c  (.clk(clk), .a(x), .b(p5), .p(c8));
  ptc_mul64 u_mul_e  (.clk(clk), .a(x), .b(p2), .p(e8));

  // Square weighted by P6 and P3.
  ptc_mul64 u_mul_b  (.clk(clk), .a(sq8), .b(p6), .p(b10));
  ptc_mul64 u_mul_d  (.clk(clk), .a(sq8), .b(p3), .p(d10));

  ptc_delay #(.WIDTH(128), .DEPTH(MUL_LAT)) u_ce_dly (
    .clk (clk), .din ({c8, e8}), .dout ({c10, e10})
  );

  // Combine into the pressure offset and the divisor precursor.
  assign d10_sh = $signed(d10) >>> 8;
  always_ff @(posedge clk) begin
    v2  <= b10 + (c10 << 17) + (p4 << 35);
    v1b <= d10_sh + (e10 << 12);
  end

  // Divisor scale by P1.
  ptc_mul64 u_mul_f (.clk(clk), .a(V1_BIAS + v1b), .b(p1), .p(f13));

  ptc_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_v2_dly (
    .clk (clk), .din (v2), .dout (v2_13)
  );

  // Divisor and dividend before scaling.
  assign f13_sh = $signed(f13) >>> 33;
  always_ff @(posedge clk) begin
    v1c <= f13_sh;
    num <= ((P_BASE - {44'd0, adc13}) << 31) - v2_13;
  end

  ptc_mul64 u_mul_g (.clk(clk), .a(num), .b(P_SCALE), .p(g16));

  ptc_delay #(.WIDTH(64), .DEPTH(MUL_LAT)) u_v1c_dly (
    .clk (clk), .din (v1c), .dout (v1c16)
  );

  ptc_delay #(.WIDTH(1), .DEPTH(PTC_LAT - 1 - 16)) u_zero_dly (
    .clk (clk), .din (v1c16 == 64'd0), .dout (zero87)
  );

  // Signed division.
  ptc_div u_div (
    .clk      (clk),
    .dividend (g16),
    .divisor  (v1c16),
    .quotient (q82)
  );

  // Second-order pressure correction.
  assign ph82 = $signed(q82) >>> 13;
  ptc_mul64 u_mul_h (.clk(clk), .a(p9), .b(ph82), .p(h84));
  ptc_mul64 u_mul_j (.clk(clk), .a(p8), .b(q82),  .p(j84));

  ptc_delay #(.WIDTH(128), .DEPTH(MUL_LAT)) u_phq_dly (
    .clk (clk), .din ({ph82, q82}), .dout ({ph84, q84})
  );

  ptc_mul64 u_mul_i (.clk(clk), .a(h84), .b(ph84), .p(i86));

  ptc_delay #(.WIDTH(128), .DEPTH(MUL_LAT)) u_qj_dly (
    .clk (clk), .din ({q84, j84}), .dout ({q86, j86})
  );

  assign i86_sh = $signed(i86) >>> 25;
  assign j86_sh = $signed(j86) >>> 19;
  always_ff @(posedge clk) begin
    s <= q86 + i86_sh + j86_sh;
  end

  // Final offset and saturation to the unsigned 32-bit range.
  assign s_sh = $signed(s) >>> 8;
  assign pfin = s_sh + (p7 << 4);
  always_comb begin
    if (pfin[63]) begin
      press_sat = 32'd0;
    end else if (pfin[63:32] != 32'd0) begin
      press_sat = 32'hffff_ffff;
    end else begin
      press_sat = pfin[31:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    result.fine_temp      <= side87[47:16];
    result.temp_centi     <= side87[15:0];
    result.pressure_q24_8 <= zero87 ? 32'd0 : press_sat;
    result.press_valid    <= !zero87;
  end

  assign done = vld[PTC_LAT-1];

`include "pressure_temp_compensation_assert.svh"

  `PTC_ASSERT_DLY(a_latency, start && !busy, PTC_LAT, done)
  `PTC_ASSERT_IMP(a_no_phantom, done, $past(start && !busy, PTC_LAT))
  `PTC_ASSERT_IMP(a_zero_div, done && !result.press_valid, result.pressure_q24_8 == 32'd0)
  `PTC_ASSERT_IMP(a_reset_quiet, $past(rst), !done)

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Testbench for pressure_temp_compensation
// Sends raw temperature and pressure readings under several calibration
// sets, and predicts each compensated result in the bench. Each done beat is
// checked field by field against the oldest prediction.
// ============================================================================
module tb_top
  import ptc_pkg::*;
;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  ptc_in_t     sample = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_TEMP_CALIB;
  logic [47:0] cfg_data = '0;
  logic        done;
  ptc_out_t    result;

  // Calibration held by the bench, updated on each config beat.
  logic [47:0] temp_cal, press_cal_a, press_cal_b, press_cal_c;

  ptc_out_t    pending_results[$];
  int          mismatches = 0;
  int          gap_odds = 4;
  int          stall_cycles = 0;

  localparam int STALL_LIMIT = 2000;

  pressure_temp_compensation dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .sample(sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .result(result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [31:0] sra32(logic [31:0] v, int n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [63:0] sra64(logic [63:0] v, int n);
    return $signed(v) >>> n;
  endfunction

  function automatic logic [63:0] word64(logic [47:0] r, int lsb);
    logic [15:0] w;
    w = r[lsb +: 16];
    return {{48{w[15]}}, w};
  endfunction

  // Integer compensation of one reading pair with the current calibration.
  function automatic ptc_out_t compensate(ptc_in_t s);
    logic [31:0] t1, t2, t3, a, tv1, d, tv2, tf, tc;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] v1, v2, p, num, mn, md, q, ph, w1, w2;
    ptc_out_t r;
    t1 = {16'b0, temp_cal[15:0]};
    t2 = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3 = {{16{temp_cal[47]}}, temp_cal[47:32]};
    a = {15'b0, s.raw_temp[19:3]} - (t1 << 1);
    tv1 = sra32(a * t2, 11);
    d = {16'b0, s.raw_temp[19:4]} - t1;
    tv2 = sra32(sra32(d * d, 12) * t3, 14);
    tf = tv1 + tv2;
    tc = sra32(tf * 32'd5 + 32'd128, 8);
    r.fine_temp = tf;
    if (tc[31]) begin
      r.temp_centi = ($signed(tc) < -32768) ? 16'h8000 : tc[15:0];
    end else begin
      r.temp_centi = (tc > 32'h7FFF) ? 16'h7FFF : tc[15:0];
    end

    p1 = {48'b0, press_cal_a[15:0]};
    p2 = word64(press_cal_a, 16);
    p3 = word64(press_cal_a, 32);
    p4 = word64(press_cal_b, 0);
    p5 = word64(press_cal_b, 16);
    p6 = word64(press_cal_b, 32);
    p7 = word64(press_cal_c, 0);
    p8 = word64(press_cal_c, 16);
    p9 = word64(press_cal_c, 32);

    v1 = {{32{tf[31]}}, tf} - T_OFFSET;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = sra64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = sra64((V1_BIAS + v1) * p1, 33);

    r.pressure_q24_8 = '0;
    r.press_valid = 1'b0;
    if (v1 != 0) begin
      p = P_BASE - {44'b0, s.raw_press};
      num = ((p << 31) - v2) * P_SCALE;
      // Signed division truncating toward zero, built on magnitudes.
      mn = num[63] ? -num : num;
      md = v1[63] ? -v1 : v1;
      q = mn / md;
      p = (num[63] != v1[63]) ? -q : q;
      ph = sra64(p, 13);
      w1 = sra64(p9 * ph * ph, 25);
      w2 = sra64(p8 * p, 19);
      p = sra64(p + w1 + w2, 8) + (p7 << 4);
      if (p[63]) r.pressure_q24_8 = '0;
      else if (p > 64'hFFFF_FFFF) r.pressure_q24_8 = 32'hFFFF_FFFF;
      else r.pressure_q24_8 = p[31:0];
      r.press_valid = 1'b1;
    end
    return r;
  endfunction

  // Compare each done beat with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat: %p", result);
      end else begin
        ptc_out_t want;
        want = pending_results.pop_front();
        if (result.fine_temp !== want.fine_temp || result.temp_centi !== want.temp_centi ||
            result.pressure_q24_8 !== want.pressure_q24_8 ||
            result.press_valid !== want.press_valid) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Result mismatch: expected %p, got %p", want, result);
        end
      end
    end
  end

  // Watchdog on cycles in which no beat moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Send one reading pair; start stays high until a gap or the next send.
  task automatic send_reading(logic [19:0] rt, logic [19:0] rp);
    ptc_in_t s;
    s.raw_temp = rt;
    s.raw_press = rp;
    sample <= s;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_results.push_back(compensate(s));
    if (gap_odds > 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  task automatic send_random_reading();
    send_reading(20'($urandom), 20'($urandom));
  endtask

  // Write all four calibration registers once the pipeline has drained.
  task automatic load_calib(logic [47:0] t, logic [47:0] a, logic [47:0] b,
                            logic [47:0] c);
    logic [47:0] vals[4];
    vals = '{t, a, b, c};
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_index <= 2'(i);
      cfg_data <= vals[i];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      case (2'(i))
        REG_TEMP_CALIB:    temp_cal = vals[i];
        REG_PRESS_CALIB_A: press_cal_a = vals[i];
        REG_PRESS_CALIB_B: press_cal_b = vals[i];
        REG_PRESS_CALIB_C: press_cal_c = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [47:0] pack_words(int lo, int mid, int hi);
    return {16'(hi), 16'(mid), 16'(lo)};
  endfunction

  // Typical factory calibration of this sensor family.
  task automatic load_typical_calib();
    load_calib(pack_words(27504, 26435, -1000), pack_words(36477, -10685, 3024),
               pack_words(2855, 140, -7), pack_words(15500, -14600, 6000));
  endtask

  // Reset calibration is all zero, so the divisor is zero.
  task automatic test_reset_state();
    send_reading(20'h00000, 20'h00000);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd519888, 20'd415148);
  endtask

  // Field extremes and a realistic pair under typical calibration.
  task automatic test_directed_readings();
    logic [19:0] corners[6];
    corners = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'h55555, 20'hAAAAA};
    load_typical_calib();
    send_reading(20'd519888, 20'd415148);
    foreach (corners[i]) begin
      send_reading(corners[i], corners[5 - i]);
      send_reading(corners[i], corners[i]);
    end
  endtask

  // P1 of zero forces a zero divisor with random other words.
  task automatic test_zero_divisor();
    load_calib(48'({$urandom, $urandom}), {32'($urandom), 16'h0000},
               48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
    repeat (4) send_random_reading();
  endtask

  // Extreme calibration words push temperature and pressure into saturation.
  task automatic test_saturation();
    load_calib('1, '1, '1, '1);
    repeat (3) send_random_reading();
    send_reading(20'hFFFFF, 20'h00000);
    load_calib(48'h7FFF_7FFF_0000, 48'h7FFF_7FFF_FFFF, 48'h7FFF_7FFF_7FFF,
               48'h7FFF_7FFF_7FFF);
    repeat (3) send_random_reading();
    send_reading(20'h00000, 20'hFFFFF);
    load_calib(48'h8000_8000_FFFF, 48'h8000_8000_0001, 48'h8000_8000_8000,
               48'h8000_8000_8000);
    repeat (3) send_random_reading();
  endtask

  // Random calibration sets: typical words with jitter, or fully random.
  task automatic test_random_calib(int phases, int per_phase, bit no_gaps);
    for (int ph = 0; ph < phases; ph++) begin
      if (ph % 2 == 0) begin
        load_calib(pack_words($urandom_range(20000, 35000), $urandom_range(20000, 30000),
                              -$urandom_range(0, 2000)),
                   pack_words($urandom_range(30000, 40000), -$urandom_range(8000, 12000),
                              $urandom_range(2000, 4000)),
                   pack_words($urandom_range(0, 9000), $urandom_range(0, 300),
                              -$urandom_range(0, 20)),
                   pack_words($urandom_range(0, 20000), -$urandom_range(0, 20000),
                              $urandom_range(0, 8000)));
      end else begin
        load_calib(48'({$urandom, $urandom}), 48'({$urandom, $urandom}),
                   48'({$urandom, $urandom}), 48'({$urandom, $urandom}));
      end
      gap_odds = (no_gaps || ph % 3 == 2) ? 0 : $urandom_range(2, 6);
      repeat (per_phase) begin
        if ($urandom_range(0, 3) == 0) send_random_reading();
        else send_reading(20'($urandom_range(300000, 700000)),
                          20'($urandom_range(200000, 700000)));
      end
    end
  endtask

  initial begin
    temp_cal = '0;
    press_cal_a = '0;
    press_cal_b = '0;
    press_cal_c = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_directed_readings();
    test_zero_divisor();
    test_saturation();
    test_random_calib(6, 95, 1'b0);
    // Closing stretch runs with no gaps at all.
    gap_odds = 0;
    test_random_calib(1, 40, 1'b1);

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (PTC_LAT + 16) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
